@@ hdl/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// shared constants and types of the set-associative tag store
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int DEF_MAX_SETS  = 64;
   localparam int DEF_MAX_WAYS  = 8;
   localparam int DEF_TIME_BITS = 32;

   localparam int ADDR_W   = 32;
   localparam int WAY_W    = 3;
   localparam int SET_W    = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 4;

   localparam int OFF_MAX = 12;
   localparam int SIB_MAX = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLICY   = 2'd0,
      CSR_OFFSET   = 2'd1,
      CSR_SET_BITS = 2'd2,
      CSR_WAYS     = 2'd3
   } csr_idx_type;

   // decoded lookup handed from the front end to the back end
   typedef struct packed {
      logic [ADDR_W-1:0] tag;
      logic [SET_W-1:0]  set_number;
   } lookup_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic             evicted;
      logic [SET_W-1:0] set_number;
   } result_type;

endpackage

@@ hdl/sacl_if.sv @@
// ----------------------------------------------------------------------------
// sacl_req_if / sacl_rsp_if
// valid/ready channels of the tag store
// ----------------------------------------------------------------------------
interface sacl_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] address;
   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface sacl_rsp_if;
   logic       valid;
   logic       ready;
   logic       hit;
   logic [2:0] way;
   logic       evicted;
   logic [5:0] set_number;
   modport source (output valid, output hit, output way, output evicted,
                   output set_number, input ready);
   modport sink   (input valid, input hit, input way, input evicted,
                   input set_number, output ready);
endinterface

@@ hdl/sacl_front.sv @@
// ----------------------------------------------------------------------------
// sacl_front
// splits the address into set and tag and queues the lookup
// ----------------------------------------------------------------------------
module sacl_front #(
   parameter int SET_BITS = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [31:0]                address,
   input  logic [3:0]                 offset_bits,
   input  logic [2:0]                 set_index_bits,
   output logic                       q_valid,
   input  logic                       q_ready,
   output sacl_pkg::lookup_type       q_data
);
   import sacl_pkg::*;

   localparam int DEPTH = 2;

   lookup_type         q_mem_ff [DEPTH];
   logic               wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [3:0]         off;
   logic [2:0]         sib;
   logic [ADDR_W-1:0]  shifted, set_mask;
   logic [SET_BITS-1:0] set_idx;
   lookup_type         item;
   logic               push, pop;

   // clamp the split and decode
   always_comb begin
      off      = (offset_bits > 4'(OFF_MAX)) ? 4'(OFF_MAX) : offset_bits;
      sib      = (set_index_bits > 3'(SIB_MAX)) ? 3'(SIB_MAX) : set_index_bits;
      shifted  = address >> off;
      set_mask = (32'd1 << sib) - 32'd1;
      set_idx  = SET_BITS'(shifted & set_mask);
      item.set_number = SET_W'(set_idx);
      item.tag        = shifted >> sib;
   end

   assign in_ready = (cnt_ff != 2'(DEPTH));
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = q_mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_mem_ff[wp_ff] <= item;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(DEPTH)) else $error("queue overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(DEPTH) |-> !push) else $error("push into full queue");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0) else $error("pop from empty queue");

endmodule

@@ hdl/sacl_back.sv @@
// ----------------------------------------------------------------------------
// sacl_back
// reads a set, compares tags, picks the victim and writes the set back
// ----------------------------------------------------------------------------
module sacl_back #(
   parameter int MAX_SETS  = 64,
   parameter int MAX_WAYS  = 8,
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  sacl_pkg::lookup_type q_data,
   input  logic                 policy,
   input  logic [3:0]           ways_in_use,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sacl_pkg::result_type rsp_data
);
   import sacl_pkg::*;

   localparam int SI_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WI_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CW        = $clog2(MAX_WAYS + 1);
   localparam int SET_CODES = 1 << SET_W;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_SCAN  = 4'b1000
   } state_type;

   // one memory row holds a whole set
   typedef struct packed {
      logic [ADDR_W-1:0]    tag;
      logic [TIME_BITS-1:0] last_use;
      logic [TIME_BITS-1:0] fill_time;
   } line_type;

   line_type             mem [MAX_SETS][MAX_WAYS];
   line_type             rd_ff [MAX_WAYS];
   logic [MAX_WAYS-1:0]  vmem [MAX_SETS];
   logic [MAX_WAYS-1:0]  vrow_ff, wr_row;
   state_type            state_ff, state_in;
   logic [SI_W-1:0]      clr_ff, clr_in;
   lookup_type           cur_ff;
   logic [SI_W-1:0]      set_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic                 out_valid_ff;
   result_type           out_ff;
   logic [CW-1:0]        ways;
   logic [MAX_WAYS-1:0]  hit_vec, free_vec;
   logic                 hit_any, free_any, do_wr;
   logic [WI_W-1:0]      hit_w, free_w, old_w, pick;
   logic [TIME_BITS-1:0] best, age;
   logic [SI_W-1:0]      q_set;

   assign ways  = (ways_in_use == 4'd0) ? CW'(1) :
                  (32'(ways_in_use) > MAX_WAYS) ? CW'(MAX_WAYS) : CW'(ways_in_use);

   // set number wrapped to the sets present, as a constant table
   always_comb begin
      q_set = '0;
      for (int s = 0; s < SET_CODES; s++) begin
         if (q_data.set_number == SET_W'(s)) q_set = SI_W'(s % MAX_SETS);
      end
   end

   assign q_ready   = (state_ff == ST_IDLE) && (!out_valid_ff || rsp_ready);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // compare and victim choice on the registered row
   always_comb begin
      hit_any = 1'b0; free_any = 1'b0;
      hit_w = '0; free_w = '0; old_w = '0;
      best = policy ? rd_ff[0].fill_time : rd_ff[0].last_use;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         hit_vec[w]  = (w < 32'(ways)) && vrow_ff[w] && (rd_ff[w].tag == cur_ff.tag);
         free_vec[w] = (w < 32'(ways)) && !vrow_ff[w];
         if (hit_vec[w])  begin hit_any = 1'b1;  hit_w = WI_W'(w); end
         if (free_vec[w]) begin free_any = 1'b1; free_w = WI_W'(w); end
      end
      for (int w = 1; w < MAX_WAYS; w++) begin
         age = policy ? rd_ff[w].fill_time : rd_ff[w].last_use;
         if ((w < 32'(ways)) && (age < best)) begin
            best = age; old_w = WI_W'(w);
         end
      end
      pick = hit_any ? hit_w : (free_any ? free_w : old_w);
      wr_row = vrow_ff;
      wr_row[pick] = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      do_wr    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SI_W'(MAX_SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (q_valid && q_ready) state_in = ST_READ;
         ST_READ: state_in = ST_SCAN;
         ST_SCAN: begin state_in = ST_IDLE; do_wr = 1'b1; end
         default: state_in = ST_IDLE;
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         time_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (state_ff == ST_IDLE && q_valid && q_ready) time_ff <= time_ff + 1'b1;
         if (do_wr) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // set memory, valid memory and payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_ready) begin
         cur_ff <= q_data;
         set_ff <= q_set;
      end
      if (state_ff == ST_CLEAR) begin
         vmem[clr_ff] <= '0;
      end else if (do_wr) begin
         vmem[set_ff] <= wr_row;
      end
      if (state_ff == ST_READ) begin
         rd_ff   <= mem[set_ff];
         vrow_ff <= vmem[set_ff];
      end
      if (do_wr) begin
         mem[set_ff][pick].last_use <= time_ff;
         if (!hit_any) begin
            mem[set_ff][pick].tag       <= cur_ff.tag;
            mem[set_ff][pick].fill_time <= time_ff;
         end
         out_ff.hit        <= hit_any;
         out_ff.way        <= WAY_W'(pick);
         out_ff.evicted    <= !hit_any && !free_any;
         out_ff.set_number <= SET_W'(set_ff);
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_wr_room: assert property (@(posedge clock) disable iff (reset)
      do_wr |-> (!out_valid_ff || rsp_ready)) else $error("result overwritten");
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.hit |-> !out_ff.evicted) else $error("hit evicted");
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !q_ready) else $error("lookup taken while clearing");

endmodule

@@ hdl/set_assoc_cache_lookup_lru.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_lru
// tag store of a set-associative cache with lru or fifo replacement
// ----------------------------------------------------------------------------
// A lookup passes through the back-end states accept, set read, and compare
// and write back, in that order; the back end takes no new lookup until the
// last one has written its set row back, since a single read/modify/write of
// a set row is in flight. A two-entry queue after the address split lets
// requests be taken while the back end is busy. After reset the back end
// clears the valid bits one set per cycle, so no lookup starts until every
// set is cleared; up to two requests are queued meanwhile.
module set_assoc_cache_lookup_lru #(
   parameter int MAX_SETS  = sacl_pkg::DEF_MAX_SETS,
   parameter int MAX_WAYS  = sacl_pkg::DEF_MAX_WAYS,
   parameter int TIME_BITS = sacl_pkg::DEF_TIME_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   sacl_req_if.sink                        req,
   sacl_rsp_if.source                      rsp,
   input  logic                            csr_write_enable,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sacl_pkg::CSR_DAT_W-1:0]  csr_write_data
);
   import sacl_pkg::*;

   logic        policy_ff;
   logic [3:0]  offset_ff;
   logic [2:0]  sib_ff;
   logic [3:0]  ways_ff;
   logic        q_valid, q_ready;
   lookup_type  q_data;
   result_type  res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 1'b0;
         offset_ff <= 4'd4;
         sib_ff    <= 3'd6;
         ways_ff   <= 4'd8;
      end else if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_POLICY:   policy_ff <= csr_write_data[0];
            CSR_OFFSET:   offset_ff <= csr_write_data;
            CSR_SET_BITS: sib_ff    <= csr_write_data[2:0];
            CSR_WAYS:     ways_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   sacl_front #(.SET_BITS(SET_W)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .address(req.address),
      .offset_bits(offset_ff), .set_index_bits(sib_ff),
      .q_valid, .q_ready, .q_data
   );

   sacl_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .TIME_BITS(TIME_BITS)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .policy(policy_ff), .ways_in_use(ways_ff),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(res)
   );

   assign rsp.hit        = res.hit;
   assign rsp.way        = res.way;
   assign rsp.evicted    = res.evicted;
   assign rsp.set_number = res.set_number;

endmodule

@@ dv/set_assoc_cache_lookup_lru_tb.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_lru_tb
// self-checking bench for the set-associative tag store: a cycle-free tag
// model predicts hit, way, eviction and set of every lookup transaction while
// the geometry and replacement policy are swept and both channels stall
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_lru_tb;
   import sacl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETS  = DEF_MAX_SETS;
   localparam int WAYS  = DEF_MAX_WAYS;
   localparam int LINES = SETS * WAYS;

   logic clock;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_write_data;

   sacl_req_if req_if ();
   sacl_rsp_if rsp_if ();

   set_assoc_cache_lookup_lru uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // tag model state and its copy of the registers
   logic        line_ok   [LINES];
   logic [31:0] line_tag_m[LINES];
   logic [31:0] last_touch[LINES];
   logic [31:0] fill_stamp[LINES];
   logic [31:0] lookup_clock;
   logic        fifo_policy;
   logic [3:0]  block_bits;
   logic [2:0]  index_bits;
   logic [3:0]  assoc;

   result_type expected_results[$];
   int  mismatches;
   int  lookups_sent;
   int  results_seen;
   int  hits_seen;
   int  evictions_seen;
   int  settings_tried;

   // sender and receiver behavior
   bit  gaps_on;
   bit  req_active;
   int  burst_left;
   int  stall_mode;
   int  hold_cycles;
   int  cycle_count;

   // predict one lookup and update the model
   function automatic result_type lookup_tag(input logic [31:0] addr);
      result_type  res;
      int unsigned off;
      int unsigned sib;
      int unsigned nways;
      int unsigned base;
      int unsigned pick;
      logic [31:0] setv;
      logic [31:0] tagv;
      logic [31:0] best;
      bit          found;
      bit          free;
      off   = (block_bits > OFF_MAX) ? OFF_MAX : block_bits;
      sib   = (index_bits > SIB_MAX) ? SIB_MAX : index_bits;
      nways = (assoc == 0) ? 1 : ((assoc > WAYS) ? WAYS : assoc);
      lookup_clock = lookup_clock + 1;
      setv  = (addr >> off) & ((32'd1 << sib) - 1);
      setv  = setv % SETS;
      tagv  = addr >> (off + sib);
      base  = setv * WAYS;
      found = 0;
      free  = 0;
      pick  = 0;
      for (int w = 0; w < nways; w++) begin
         if (!found && line_ok[base+w] && line_tag_m[base+w] == tagv) begin
            found = 1;
            pick  = w;
         end
      end
      res.set_number = setv[SET_W-1:0];
      if (found) begin
         last_touch[base+pick] = lookup_clock;
         res.hit     = 1'b1;
         res.way     = pick[WAY_W-1:0];
         res.evicted = 1'b0;
         return res;
      end
      for (int w = 0; w < nways; w++) begin
         if (!free && !line_ok[base+w]) begin
            free = 1;
            pick = w;
         end
      end
      if (!free) begin
         // oldest fill or least recent use, lowest way on a tie
         pick = 0;
         best = fifo_policy ? fill_stamp[base] : last_touch[base];
         for (int w = 1; w < nways; w++) begin
            if ((fifo_policy ? fill_stamp[base+w] : last_touch[base+w]) < best) begin
               best = fifo_policy ? fill_stamp[base+w] : last_touch[base+w];
               pick = w;
            end
         end
      end
      res.hit     = 1'b0;
      res.way     = pick[WAY_W-1:0];
      res.evicted = line_ok[base+pick];
      line_ok[base+pick]    = 1'b1;
      line_tag_m[base+pick] = tagv;
      last_touch[base+pick] = lookup_clock;
      fill_stamp[base+pick] = lookup_clock;
      return res;
   endfunction

   // offer one address and wait for the transaction
   task automatic send_address(input logic [31:0] addr);
      int gap;
      req_if.valid   <= 1'b1;
      req_if.address <= addr;
      req_active = 1;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(lookup_tag(addr));
      lookups_sent++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            req_if.valid <= 1'b0;
            req_active = 0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain_lookups();
      if (req_active) begin
         req_if.valid <= 1'b0;
         req_active = 0;
      end
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // one register write; the caller drops the enable after the last one
   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DAT_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_POLICY:   fifo_policy = data[0];
         CSR_OFFSET:   block_bits  = data[3:0];
         CSR_SET_BITS: index_bits  = data[2:0];
         CSR_WAYS:     assoc       = data[3:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic pol, input logic [3:0] off,
                                input logic [2:0] sib, input logic [3:0] nways);
      drain_lookups();
      write_csr(CSR_POLICY, {3'b0, pol});
      write_csr(CSR_OFFSET, off);
      write_csr(CSR_SET_BITS, {1'b0, sib});
      write_csr(CSR_WAYS, nways);
      csr_write_enable <= 1'b0;
      settings_tried++;
   endtask

   // mostly a small tag pool over a few sets so hits and evictions are common
   function automatic logic [31:0] pick_address();
      int unsigned off;
      int unsigned sib;
      int unsigned pool;
      logic [31:0] a;
      if ($urandom_range(0, 7) == 0) return $urandom;
      off  = (block_bits > OFF_MAX) ? OFF_MAX : block_bits;
      sib  = (index_bits > SIB_MAX) ? SIB_MAX : index_bits;
      pool = ((assoc == 0) ? 1 : ((assoc > WAYS) ? WAYS : assoc)) + 3;
      a = $urandom & ((32'd1 << off) - 1);
      a = a | (((32'($urandom_range(0, 3))) & ((32'd1 << sib) - 1)) << off);
      a = a | (32'($urandom_range(0, pool - 1)) << (off + sib));
      if ($urandom_range(0, 5) == 0) a[31] = 1'b1;
      return a;
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) send_address(pick_address());
   endtask

   // reset defaults: fill all ways of one set, evict, then hit again
   task automatic test_fill_and_evict();
      stall_mode = 0;
      gaps_on = 0;
      send_address(32'h0000_0000);
      send_address(32'hFFFF_FFFF);
      send_address(32'h0000_000F);
      for (int t = 1; t <= 9; t++) send_address(32'(t) << 10);
      send_address(32'h0000_0000);
      send_address(32'h0000_2400);
      send_address(32'h0000_03F0);
      send_address(32'hAAAA_5555);
      send_address(32'h5555_AAAA);
      drain_lookups();
   endtask

   // geometry and policy sweep including out-of-range register values
   task automatic test_setting_sweep();
      apply_setting(1'b1, 4'd4, 3'd6, 4'd8);
      run_random(40);
      apply_setting(1'b0, 4'd0, 3'd0, 4'd1);
      gaps_on = 1;
      stall_mode = 1;
      run_random(30);
      apply_setting(1'b1, 4'd12, 3'd6, 4'd15);
      run_random(40);
      apply_setting(1'b0, 4'd15, 3'd7, 4'd0);
      stall_mode = 2;
      run_random(30);
      apply_setting(1'b1, 4'd3, 3'd1, 4'd4);
      run_random(40);
      // new split over the lines already stored
      apply_setting(1'b0, 4'd5, 3'd2, 4'd4);
      run_random(40);
      apply_setting(1'b1, 4'd0, 3'd3, 4'd2);
      stall_mode = 0;
      gaps_on = 0;
      run_random(40);
      drain_lookups();
   endtask

   // long receiver hold while the sender keeps offering
   task automatic test_backpressure();
      apply_setting(1'b0, 4'd4, 3'd2, 4'd3);
      gaps_on = 0;
      stall_mode = 0;
      hold_cycles = 120;
      run_random(40);
      drain_lookups();
   endtask

   // random settings with varied idling on both sides
   task automatic test_random_mix();
      for (int p = 0; p < 10; p++) begin
         apply_setting(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
         gaps_on = 1'($urandom_range(0, 1));
         stall_mode = $urandom_range(0, 2);
         run_random(40);
      end
      drain_lookups();
   endtask

   // receiver ready: hold-off, random stalls or a fixed pattern
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_cycles--;
      end else begin
         case (stall_mode)
            1: rsp_if.ready <= ($urandom_range(0, 9) > 2);
            2: rsp_if.ready <= ((cycle_count % 7) > 1);
            default: rsp_if.ready <= 1'b1;
         endcase
      end
   end

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (rsp_if.hit) hits_seen++;
         if (rsp_if.evicted) evictions_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("error: result with nothing outstanding, hit %0b way %0d set %0d",
                        rsp_if.hit, rsp_if.way, rsp_if.set_number);
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.hit !== want.hit || rsp_if.way !== want.way ||
                rsp_if.evicted !== want.evicted || rsp_if.set_number !== want.set_number) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"error: result %0d expected hit %0b way %0d evicted %0b",
                            " set %0d, got hit %0b way %0d evicted %0b set %0d"},
                           results_seen, want.hit, want.way, want.evicted, want.set_number,
                           rsp_if.hit, rsp_if.way, rsp_if.evicted, rsp_if.set_number);
            end
         end
      end
   end

   // watchdog
   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   initial begin
      req_if.valid     <= 1'b0;
      req_if.address   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_POLICY;
      csr_write_data   <= '0;
      reset            <= 1'b1;
      for (int i = 0; i < LINES; i++) line_ok[i] = 1'b0;
      lookup_clock = '0;
      fifo_policy  = 1'b0;
      block_bits   = 4'd4;
      index_bits   = 3'd6;
      assoc        = 4'd8;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_and_evict();
      test_setting_sweep();
      test_backpressure();
      test_random_mix();

      if (expected_results.size() != 0) begin
         mismatches++;
         $display("error: %0d results never arrived", expected_results.size());
      end
      $display("covered %0d lookups over %0d register settings", lookups_sent, settings_tried);
      $display("saw %0d hits and %0d evictions, %0d mismatches",
               hits_seen, evictions_seen, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
